/* rtl/core/assert_macros.svh */
// Assertion macros used by the multi-stack unit RTL.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// antecedent implies consequent in the same cycle
`define ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// antecedent implies consequent in the next cycle
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

/* rtl/core/msa_pkg.sv */
// Package for the shared-array multi-stack unit: sizes, transaction types, codes.
// No dependencies.
package msa_pkg;

   localparam int CAPACITY   = 16;
   localparam int MAX_STACKS = 8;
   localparam int ADDR_W     = $clog2(CAPACITY);
   localparam int CNT_W      = $clog2(CAPACITY + 1);
   localparam int IDX_W      = 3;
   localparam int NUM_W      = 4;
   localparam int SUM_W      = CNT_W + IDX_W;
   localparam int ID_W       = 8;
   localparam int NAME_W     = 64;
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;

   localparam logic [CSR_ADDR_W-3:0] REG_NUM_STACKS = '0;
   localparam logic                  OP_PUSH        = 1'b0;
   localparam logic                  OP_POP         = 1'b1;

   typedef enum logic [1:0] {
      ST_OK        = 2'd0,
      ST_FULL      = 2'd1,
      ST_EMPTY     = 2'd2,
      ST_BAD_INDEX = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      S_IDLE,
      S_EVAL,
      S_RESP
   } state_type;

   typedef struct packed {
      logic              operation;
      logic [IDX_W-1:0]  stack_index;
      logic [ID_W-1:0]   entry_id;
      logic [NAME_W-1:0] entry_name;
   } req_type;

   typedef struct packed {
      status_type        status;
      logic [ID_W-1:0]   popped_id;
      logic [NAME_W-1:0] popped_name;
   } rsp_type;

   typedef struct packed {
      logic [ID_W-1:0]   id;
      logic [NAME_W-1:0] name;
   } entry_type;

   typedef struct packed {
      logic load;
      logic eval;
   } ctrl_cmd_type;

   function automatic logic [NUM_W-1:0] eff_stacks(input logic [NUM_W-1:0] num);
      logic [NUM_W-1:0] n;
      n = num;
      if (n == '0) n = NUM_W'(1);
      if (int'(n) > MAX_STACKS) n = NUM_W'(MAX_STACKS);
      if (int'(n) > CAPACITY) n = NUM_W'(CAPACITY);
      return n;
   endfunction

   function automatic logic [CNT_W-1:0] seg_size(input logic [NUM_W-1:0] n);
      logic [CNT_W-1:0] s;
      unique case (n)
         4'd1:    s = CNT_W'(CAPACITY / 1);
         4'd2:    s = CNT_W'(CAPACITY / 2);
         4'd3:    s = CNT_W'(CAPACITY / 3);
         4'd4:    s = CNT_W'(CAPACITY / 4);
         4'd5:    s = CNT_W'(CAPACITY / 5);
         4'd6:    s = CNT_W'(CAPACITY / 6);
         4'd7:    s = CNT_W'(CAPACITY / 7);
         4'd8:    s = CNT_W'(CAPACITY / 8);
         4'd9:    s = CNT_W'(CAPACITY / 9);
         4'd10:   s = CNT_W'(CAPACITY / 10);
         4'd11:   s = CNT_W'(CAPACITY / 11);
         4'd12:   s = CNT_W'(CAPACITY / 12);
         4'd13:   s = CNT_W'(CAPACITY / 13);
         4'd14:   s = CNT_W'(CAPACITY / 14);
         4'd15:   s = CNT_W'(CAPACITY / 15);
         default: s = CNT_W'(CAPACITY);
      endcase
      return s;
   endfunction

endpackage

/* rtl/core/msa_ctrl.sv */
// Controller state machine for the multi-stack unit.
// Depends on msa_pkg.
module msa_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   output logic                  rsp_valid,
   output msa_pkg::ctrl_cmd_type cmd
);

   msa_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= msa_pkg::S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      unique case (state_ff)
         msa_pkg::S_IDLE: begin
            state_in = start ? msa_pkg::S_EVAL : msa_pkg::S_IDLE;
         end
         msa_pkg::S_EVAL: begin
            state_in = msa_pkg::S_RESP;
         end
         msa_pkg::S_RESP: begin
            state_in = start ? msa_pkg::S_EVAL : msa_pkg::S_IDLE;
         end
         default: begin
            state_in = msa_pkg::S_IDLE;
         end
      endcase
   end

   always_comb begin
      busy      = (state_ff == msa_pkg::S_EVAL);
      rsp_valid = (state_ff == msa_pkg::S_RESP);
      cmd.eval  = (state_ff == msa_pkg::S_EVAL);
      cmd.load  = start && !busy;
   end

endmodule

/* rtl/core/msa_datapath.sv */
// Datapath: request register, top counters, shared entry store, result registers.
// Depends on msa_pkg.
module msa_datapath (
   input  logic                              clock,
   input  logic                              reset,
   input  msa_pkg::ctrl_cmd_type             cmd,
   input  msa_pkg::req_type                  req_data,
   input  logic [msa_pkg::NUM_W-1:0]         num_stacks,
   input  logic                              clear_tops,
   output msa_pkg::rsp_type                  rsp_data
);

   localparam int AW = msa_pkg::ADDR_W;
   localparam int CW = msa_pkg::CNT_W;
   localparam int SW = msa_pkg::SUM_W;

   msa_pkg::req_type   req_ff;
   logic [CW-1:0]      count_ff [msa_pkg::MAX_STACKS];
   msa_pkg::entry_type store [msa_pkg::CAPACITY];
   msa_pkg::entry_type rd_data_ff;
   msa_pkg::status_type status_ff, status_in;
   logic               pop_ok_ff, pop_ok_in;

   logic [msa_pkg::NUM_W-1:0] n;
   logic [CW-1:0]             seg;
   logic [CW-1:0]             cnt;
   logic [SW-1:0]             base;
   logic [SW-1:0]             limit;
   logic [SW-1:0]             top;
   logic                      push_ok;
   logic                      is_last;

   always_comb begin
      n       = msa_pkg::eff_stacks(num_stacks);
      seg     = msa_pkg::seg_size(n);
      cnt     = count_ff[req_ff.stack_index];
      base    = SW'(seg) * SW'(req_ff.stack_index);
      is_last = (msa_pkg::NUM_W'(req_ff.stack_index) == n - msa_pkg::NUM_W'(1));
      limit   = is_last ? SW'(msa_pkg::CAPACITY) : base + SW'(seg);
      top     = base + SW'(cnt);
      push_ok   = 1'b0;
      pop_ok_in = 1'b0;
      if (msa_pkg::NUM_W'(req_ff.stack_index) >= n) begin
         status_in = msa_pkg::ST_BAD_INDEX;
      end else if (req_ff.operation == msa_pkg::OP_PUSH) begin
         if (top >= limit) begin
            status_in = msa_pkg::ST_FULL;
         end else begin
            status_in = msa_pkg::ST_OK;
            push_ok   = 1'b1;
         end
      end else begin
         if (cnt == '0) begin
            status_in = msa_pkg::ST_EMPTY;
         end else begin
            status_in = msa_pkg::ST_OK;
            pop_ok_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         req_ff <= req_data;
      end
      if (cmd.eval) begin
         status_ff <= status_in;
         pop_ok_ff <= pop_ok_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.eval && push_ok) begin
         store[top[AW-1:0]] <= '{id: req_ff.entry_id, name: req_ff.entry_name};
      end
      if (cmd.eval && pop_ok_in) begin
         rd_data_ff <= store[top[AW-1:0] - AW'(1)];
      end
   end

   always_ff @(posedge clock) begin
      if (reset || clear_tops) begin
         for (int i = 0; i < msa_pkg::MAX_STACKS; i++) begin
            count_ff[i] <= '0;
         end
      end else if (cmd.eval && push_ok) begin
         count_ff[req_ff.stack_index] <= cnt + CW'(1);
      end else if (cmd.eval && pop_ok_in) begin
         count_ff[req_ff.stack_index] <= cnt - CW'(1);
      end
   end

   always_comb begin
      rsp_data.status      = status_ff;
      rsp_data.popped_id   = pop_ok_ff ? rd_data_ff.id : '0;
      rsp_data.popped_name = pop_ok_ff ? rd_data_ff.name : '0;
   end

endmodule

/* rtl/core/multi_stack_shared_array_unit.sv */
// Multi-stack unit: one shared entry store split into per-stack segments.
// The result is strobed in the respond state, after the evaluate state that
// the accepting edge enters. A new transaction is accepted in respond, not in
// evaluate, around the single store port; busy is high in the evaluate cycle.
// Reset (synchronous, active high): all stacks empty, num_stacks = 1.
// Results are strobed for one cycle; the receiver cannot stall.
`include "assert_macros.svh"

module multi_stack_shared_array_unit (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 start,
   output logic                                 busy,
   input  msa_pkg::req_type                     req_data,
   output logic                                 rsp_valid,
   output msa_pkg::rsp_type                     rsp_data,
   input  logic                                 psel,
   input  logic                                 penable,
   input  logic                                 pwrite,
   input  logic [msa_pkg::CSR_ADDR_W-1:0]       paddr,
   input  logic [msa_pkg::CSR_DATA_W-1:0]       pwdata,
   output logic [msa_pkg::CSR_DATA_W-1:0]       prdata,
   output logic                                 pready
);

   localparam int AW = msa_pkg::CSR_ADDR_W;

   msa_pkg::ctrl_cmd_type        cmd;
   logic [msa_pkg::NUM_W-1:0]    num_stacks_ff;
   logic                         reg_sel;
   logic                         csr_wr;
   logic                         rsp_fail;
   logic                         rsp_blank;

   assign pready  = 1'b1;
   assign reg_sel = (paddr[AW-1:2] == msa_pkg::REG_NUM_STACKS);
   assign csr_wr  = psel && penable && pwrite && reg_sel;

   always_ff @(posedge clock) begin
      if (reset) begin
         num_stacks_ff <= msa_pkg::NUM_W'(1);
      end else if (csr_wr) begin
         num_stacks_ff <= pwdata[msa_pkg::NUM_W-1:0];
      end
   end

   assign prdata = reg_sel ? msa_pkg::CSR_DATA_W'(num_stacks_ff) : '0;

   msa_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .rsp_valid (rsp_valid),
      .cmd       (cmd)
   );

   msa_datapath u_datapath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .req_data   (req_data),
      .num_stacks (num_stacks_ff),
      .clear_tops (csr_wr),
      .rsp_data   (rsp_data)
   );

   assign rsp_fail  = rsp_valid && (rsp_data.status != msa_pkg::ST_OK);
   assign rsp_blank = (rsp_data.popped_id == '0) && (rsp_data.popped_name == '0);

   `ASSERT_NEXT(a_eval_then_resp, clock, reset, busy, rsp_valid && !busy)
   `ASSERT_NEXT(a_accept_goes_busy, clock, reset, start && !busy, busy)
   `ASSERT_SAME(a_fail_no_data, clock, reset, rsp_fail, rsp_blank)
   `ASSERT_NEXT(a_single_strobe, clock, reset, rsp_valid, !rsp_valid)

endmodule

/* tb/multi_stack_shared_array_unit_tb.sv */
// Self-checking testbench for multi_stack_shared_array_unit: push/pop traffic on the
// shared-array stacks, num_stacks rewrites over the CSR port, per-field result checks.
// Depends on msa_pkg and the multi_stack_shared_array_unit RTL.
`timescale 1ns / 1ps

module multi_stack_shared_array_unit_tb;
   import msa_pkg::*;

   localparam int                    CYCLE_LIMIT = 200000;
   localparam int                    SETTLE      = 3;
   localparam logic [CSR_ADDR_W-3:0] REG_SPARE   = 1'b1;

   typedef enum logic [1:0] {
      JOB_OP,
      JOB_CSR_WRITE,
      JOB_HOLD
   } job_kind_type;

   typedef struct {
      job_kind_type            kind;
      logic                    no_gap;
      req_type                 req;
      logic [CSR_ADDR_W-1:0]   addr;
      logic [CSR_DATA_W-1:0]   data;
   } stack_job_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  start = 1'b0;
   logic                  busy;
   req_type               req_data = '0;
   logic                  rsp_valid;
   rsp_type               rsp_data;
   logic                  psel = 1'b0;
   logic                  penable = 1'b0;
   logic                  pwrite = 1'b1;
   logic [CSR_ADDR_W-1:0] paddr = '0;
   logic [CSR_DATA_W-1:0] pwdata = '0;
   logic [CSR_DATA_W-1:0] prdata;
   logic                  pready;

   stack_job_type job_q[$];
   rsp_type       pending_results[$];
   logic          op_taken = 1'b0;
   int            quiet_cycles = 0;
   int            cycle_count = 0;
   int            mismatch_count = 0;

   logic [NUM_W-1:0] model_num_stacks;
   int               model_fill [MAX_STACKS];
   entry_type        model_slots [CAPACITY];

   multi_stack_shared_array_unit i_dut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .psel      (psel),
      .penable   (penable),
      .pwrite    (pwrite),
      .paddr     (paddr),
      .pwdata    (pwdata),
      .prdata    (prdata),
      .pready    (pready)
   );

   initial begin
      forever #2 clock = ~clock;
   end

   task automatic report_mismatch(input string msg);
      $display("ERROR @%0t: %s", $time, msg);
      mismatch_count++;
   endtask

   function automatic rsp_type predict_stack_op(input req_type r);
      rsp_type res;
      int      n;
      int      idx;
      int      seg;
      int      base;
      int      limit;
      int      fill;
      res = '0;
      res.status = ST_OK;
      n = model_num_stacks;
      if (n == 0) n = 1;
      if (n > MAX_STACKS) n = MAX_STACKS;
      if (n > CAPACITY) n = CAPACITY;
      idx = r.stack_index;
      if (idx >= n) begin
         res.status = ST_BAD_INDEX;
      end else begin
         seg   = CAPACITY / n;
         base  = seg * idx;
         limit = (idx == n - 1) ? CAPACITY : seg * (idx + 1);
         fill  = model_fill[idx];
         if (r.operation == OP_PUSH) begin
            if (base + fill >= limit) begin
               res.status = ST_FULL;
            end else begin
               model_slots[base + fill] = {r.entry_id, r.entry_name};
               model_fill[idx] = fill + 1;
            end
         end else if (fill == 0) begin
            res.status = ST_EMPTY;
         end else begin
            res.popped_id   = model_slots[base + fill - 1].id;
            res.popped_name = model_slots[base + fill - 1].name;
            model_fill[idx] = fill - 1;
         end
      end
      return res;
   endfunction

   // monitor and predictor
   always @(posedge clock) begin
      rsp_type want;
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("multi_stack_shared_array_unit test failed");
         $finish;
      end else if (reset) begin
         model_num_stacks = NUM_W'(1);
         foreach (model_fill[i]) model_fill[i] = 0;
         op_taken     = 1'b0;
         quiet_cycles = 0;
      end else begin
         if (rsp_valid) begin
            if (pending_results.size() == 0) begin
               report_mismatch($sformatf("result with no transaction outstanding: %h", rsp_data));
            end else begin
               want = pending_results.pop_front();
               if (rsp_data.status !== want.status)
                  report_mismatch($sformatf("status %0d, want %0d",
                                            rsp_data.status, want.status));
               if (rsp_data.popped_id !== want.popped_id)
                  report_mismatch($sformatf("popped_id %h, want %h",
                                            rsp_data.popped_id, want.popped_id));
               if (rsp_data.popped_name !== want.popped_name)
                  report_mismatch($sformatf("popped_name %h, want %h",
                                            rsp_data.popped_name, want.popped_name));
            end
         end
         op_taken = start && !busy;
         if (op_taken) pending_results.push_back(predict_stack_op(req_data));
         if (psel && penable && pwrite && pready &&
             paddr[CSR_ADDR_W-1:2] == REG_NUM_STACKS) begin
            model_num_stacks = pwdata[NUM_W-1:0];
            foreach (model_fill[i]) model_fill[i] = 0;
         end
         if (pending_results.size() == 0 && !op_taken) quiet_cycles++;
         else quiet_cycles = 0;
      end
   end

   // driver
   always @(negedge clock) begin
      stack_job_type job;
      logic          drive_start;
      logic          drive_sel;
      logic          drive_enable;
      drive_start  = start;
      drive_sel    = psel;
      drive_enable = penable;
      if (!reset && !(start && !op_taken)) begin
         if (psel && !penable) begin
            drive_enable = 1'b1;
         end else begin
            drive_start  = 1'b0;
            drive_sel    = 1'b0;
            drive_enable = 1'b0;
            if (job_q.size() != 0) begin
               job = job_q[0];
               case (job.kind)
                  JOB_OP: begin
                     if (job.no_gap || $urandom_range(99) >= 17) begin
                        drive_start = 1'b1;
                        req_data <= job.req;
                        void'(job_q.pop_front());
                     end
                  end
                  JOB_CSR_WRITE: begin
                     if (pending_results.size() == 0 && quiet_cycles >= SETTLE) begin
                        drive_sel = 1'b1;
                        paddr  <= job.addr;
                        pwdata <= job.data;
                        void'(job_q.pop_front());
                     end
                  end
                  default: begin
                     if (pending_results.size() == 0 && quiet_cycles >= SETTLE)
                        void'(job_q.pop_front());
                  end
               endcase
            end
         end
      end
      start   <= drive_start;
      psel    <= drive_sel;
      penable <= drive_enable;
   end

   function automatic void queue_op(input logic op, input int idx, input logic [ID_W-1:0] id,
                                    input logic [NAME_W-1:0] name, input logic no_gap = 1'b0);
      stack_job_type job;
      job.kind                = JOB_OP;
      job.no_gap              = no_gap;
      job.req.operation       = op;
      job.req.stack_index     = IDX_W'(idx);
      job.req.entry_id        = id;
      job.req.entry_name      = name;
      job.addr                = '0;
      job.data                = '0;
      job_q.push_back(job);
   endfunction

   function automatic void queue_write(input logic [CSR_ADDR_W-3:0] reg_index,
                                       input logic [NUM_W-1:0] value);
      stack_job_type job;
      job.kind   = JOB_CSR_WRITE;
      job.no_gap = 1'b0;
      job.req    = '0;
      job.addr   = {reg_index, 2'b00};
      job.data   = {(CSR_DATA_W - NUM_W)'($urandom_range(32'h0fff_ffff)), value};
      job_q.push_back(job);
   endfunction

   function automatic void queue_hold();
      stack_job_type job;
      job.kind   = JOB_HOLD;
      job.no_gap = 1'b0;
      job.req    = '0;
      job.addr   = '0;
      job.data   = '0;
      job_q.push_back(job);
   endfunction

   function automatic logic [NAME_W-1:0] rand_name();
      case ($urandom_range(9))
         0:       return '0;
         1:       return '1;
         default: return {$urandom, $urandom};
      endcase
   endfunction

   initial begin
      int   cfg_plan [11];
      int   cfg;
      int   active;
      int   run_left;
      int   push_pct;
      int   focus;
      int   idx;
      logic op;
      cfg_plan = '{1, 8, 3, 5, 2, 7, 4, 6, 0, 9, 15};

      // directed: one stack after reset
      queue_op(OP_POP, 0, 8'h00, '0);
      queue_op(OP_PUSH, 7, 8'h12, '1);
      queue_op(OP_PUSH, 1, 8'h34, 64'h1);
      queue_op(OP_PUSH, 0, 8'h00, '0);
      queue_op(OP_PUSH, 0, 8'hff, '1);
      queue_op(OP_POP, 0, 8'h00, '0);
      queue_op(OP_POP, 0, 8'hff, '1);
      queue_op(OP_POP, 0, 8'h00, '0);
      // eight stacks, two entries each
      queue_write(REG_NUM_STACKS, 4'd8);
      queue_op(OP_PUSH, 7, 8'ha5, 64'h0123_4567_89ab_cdef);
      queue_op(OP_PUSH, 7, 8'h5a, 64'hfedc_ba98_7654_3210);
      queue_op(OP_PUSH, 7, 8'h77, 64'h7777);
      queue_op(OP_POP, 7, 8'h00, '0);
      queue_op(OP_POP, 7, 8'h00, '0);
      queue_op(OP_PUSH, 0, 8'h01, 64'h1);
      queue_op(OP_PUSH, 0, 8'h02, 64'h2);
      queue_op(OP_PUSH, 0, 8'h03, 64'h3);
      queue_op(OP_POP, 3, 8'h00, '0);
      // spare register index must not disturb the stacks
      queue_write(REG_SPARE, 4'd3);
      queue_op(OP_POP, 0, 8'h00, '0);
      queue_op(OP_PUSH, 5, 8'h55, 64'h55);
      // zero behaves as one stack
      queue_write(REG_NUM_STACKS, 4'd0);
      queue_op(OP_PUSH, 3, 8'h99, 64'h99);
      queue_op(OP_POP, 0, 8'h00, '0);
      // above the maximum clamps to eight
      queue_write(REG_NUM_STACKS, 4'd15);
      queue_op(OP_PUSH, 7, 8'hc3, 64'hc3);
      queue_op(OP_POP, 7, 8'h00, '0);

      for (int phase = 0; phase < 13; phase++) begin
         cfg = (phase < 11) ? cfg_plan[phase] : $urandom_range(15);
         queue_write(REG_NUM_STACKS, NUM_W'(cfg));
         active = (cfg == 0) ? 1 : ((cfg > MAX_STACKS) ? MAX_STACKS : cfg);
         run_left = 0;
         push_pct = 15;
         focus    = 0;
         for (int k = 0; k < 100; k++) begin
            if (run_left == 0) begin
               run_left = $urandom_range(8, 24);
               push_pct = 100 - push_pct;
               focus    = $urandom_range(active - 1);
            end
            run_left--;
            if (phase == 5 && k == 50) queue_hold();
            op = ($urandom_range(99) < push_pct) ? OP_PUSH : OP_POP;
            case ($urandom_range(9))
               0:       idx = $urandom_range(MAX_STACKS - 1);
               1, 2:    idx = $urandom_range(active - 1);
               default: idx = focus;
            endcase
            queue_op(op, idx, ID_W'($urandom_range(255)), rand_name(), phase == 3);
         end
      end

      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      while (job_q.size() != 0 || start || psel || pending_results.size() != 0)
         @(negedge clock);
      repeat (8) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("multi_stack_shared_array_unit test passed");
      end else begin
         $display("multi_stack_shared_array_unit test failed");
      end
      $finish;
   end

endmodule
